>>> sv/kft_pkg.sv
// shared types and constants for the keyed ordered table
package kft_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // request kinds
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_FIND   = 1'b1;

  // result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // one stored entry
  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] value;
  } entry_t;

  // write request into the entry memory
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } wr_req_t;

endpackage

>>> sv/kft_ram.sv
// entry memory: one write port, one registered read port
module kft_ram
  import kft_pkg::*;
(
  input  logic              clk,
  input  wr_req_t           wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/keyed_fifo_table_find_remove_top.sv
// keyed ordered table: append at tail, find oldest match and remove it
// an append goes from the input transfer straight to the result state; a find first
//   scans the entries up to the match (or the whole count on a miss), then moves
//   the entries behind the match one slot toward the head
// throughput: one request at a time; a find is paced by the single read port
//   of the entry memory walking the entries
// reset: synchronous, empties the table and drops any pending result
module keyed_fifo_table_find_remove_top
  import kft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  coord_x,
  input  logic [7:0]  coord_y,
  input  logic [15:0] item_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [15:0] found_value,
  output logic [6:0]  entry_count,
  output logic        status
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  occ;
  logic [CNT_W-1:0]  idx;
  logic [7:0]        key_x;
  logic [7:0]        key_y;
  logic              res_hit;
  logic [15:0]       res_value;
  logic              res_status;

  wr_req_t           wr;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_data;

  logic [CNT_W-1:0]  idx_p1;
  logic [CNT_W-1:0]  idx_p2;
  logic              match;
  logic              in_xfer;
  logic              out_free;

  assign idx_p1   = idx + CNT_W'(1);
  assign idx_p2   = idx + CNT_W'(2);
  assign match    = (rd_data.x == key_x) && (rd_data.y == key_y);
  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // memory port control
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = idx[ADDR_W-1:0];
    wr.data = rd_data;
    rd_addr = '0;
    unique case (state)
      ST_IDLE: begin
        wr.en   = in_xfer && (req_type == REQ_APPEND) && (occ != CNT_W'(CAPACITY));
        wr.addr = occ[ADDR_W-1:0];
        wr.data = '{x: coord_x, y: coord_y, value: item_value};
      end
      // look ahead one entry while comparing the current one
      ST_SCAN:  rd_addr = idx_p1[ADDR_W-1:0];
      // move the entry behind the gap down, fetch the next one
      ST_SHIFT: begin
        wr.en   = 1'b1;
        rd_addr = idx_p2[ADDR_W-1:0];
      end
      ST_RESP:  rd_addr = '0;
      default:  rd_addr = '0;
    endcase
  end

  kft_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      // result transfer done, unless a new result loads in the same cycle
      if (out_valid && !out_stall && (state != ST_RESP)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            key_x      <= coord_x;
            key_y      <= coord_y;
            res_hit    <= 1'b0;
            res_value  <= '0;
            res_status <= STATUS_OK;
            idx        <= '0;
            if (req_type == REQ_APPEND) begin
              if (occ == CNT_W'(CAPACITY)) begin
                res_status <= STATUS_FULL;
              end else begin
                occ <= occ + CNT_W'(1);
              end
              state <= ST_RESP;
            end else if (occ == '0) begin
              state <= ST_RESP;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (match) begin
            res_hit   <= 1'b1;
            res_value <= rd_data.value;
            if (idx_p1 == occ) begin
              occ   <= occ - CNT_W'(1);
              state <= ST_RESP;
            end else begin
              state <= ST_SHIFT;
            end
          end else if (idx_p1 == occ) begin
            state <= ST_RESP;
          end else begin
            idx <= idx_p1;
          end
        end
        ST_SHIFT: begin
          if (idx_p2 == occ) begin
            occ   <= occ - CNT_W'(1);
            state <= ST_RESP;
          end else begin
            idx <= idx_p1;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_RESP && out_free) begin
      hit         <= res_hit;
      found_value <= res_value;
      entry_count <= 7'(occ);
      status      <= res_status;
    end
  end

endmodule

>>> sv/kft_checker.sv
// port-level checks for the keyed ordered table, bound to the top level
module kft_checker
  import kft_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        hit,
  input logic [15:0] found_value,
  input logic [6:0]  entry_count,
  input logic        status
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(found_value)
      && $stable(entry_count) && $stable(status))
    else $error("stalled result changed");

  // a refused append never reports a hit
  a_full_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_FULL) |-> !hit && (found_value == 16'd0))
    else $error("refused append with hit data");

  // a refused append only happens on a full table
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_FULL) |-> (entry_count == 7'(CAPACITY)))
    else $error("full status with table not full");

  // a miss gives a zero value
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> (found_value == 16'd0))
    else $error("miss with nonzero value");

  // a new request is not taken while the previous one is still at work
  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken back to back");

endmodule

bind keyed_fifo_table_find_remove_top kft_checker u_kft_checker (.*);

>>> verif/keyed_fifo_table_find_remove_top_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the keyed ordered table: append, find and remove
module keyed_fifo_table_find_remove_top_tb;
  import kft_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int PHASE_B_START = 360;
  localparam int PHASE_C_START = 720;
  localparam int HOLD_LEN      = 300;
  localparam int DRAIN_CYCLES  = 2 * CAPACITY + 16;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic        kind;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] found_value;
    logic [6:0]  entry_count;
    logic        status;
  } res_t;

  typedef struct packed {
    req_t req;
    logic known;
    res_t res;
  } row_t;

  localparam res_t NO_RES = '0;

  // directed rows: typed result where it is obvious, otherwise predicted
  localparam row_t DIRECTED_ROWS [0:19] = '{
    // find on an empty table
    '{'{REQ_FIND,   8'h00, 8'h00, 16'h0000}, 1'b1, '{1'b0, 16'h0000, 7'd0, STATUS_OK}},
    // field extremes
    '{'{REQ_APPEND, 8'h00, 8'h00, 16'h0000}, 1'b1, '{1'b0, 16'h0000, 7'd1, STATUS_OK}},
    '{'{REQ_APPEND, 8'hff, 8'hff, 16'hffff}, 1'b1, '{1'b0, 16'h0000, 7'd2, STATUS_OK}},
    '{'{REQ_APPEND, 8'haa, 8'h55, 16'h5aa5}, 1'b1, '{1'b0, 16'h0000, 7'd3, STATUS_OK}},
    '{'{REQ_APPEND, 8'h55, 8'haa, 16'ha55a}, 1'b1, '{1'b0, 16'h0000, 7'd4, STATUS_OK}},
    '{'{REQ_FIND,   8'hff, 8'hff, 16'h0000}, 1'b1, '{1'b1, 16'hffff, 7'd3, STATUS_OK}},
    // misses, one with only a partial coordinate match
    '{'{REQ_FIND,   8'hff, 8'hff, 16'h0000}, 1'b1, '{1'b0, 16'h0000, 7'd3, STATUS_OK}},
    '{'{REQ_FIND,   8'h55, 8'h55, 16'h0000}, 1'b1, '{1'b0, 16'h0000, 7'd3, STATUS_OK}},
    // equal coordinates: oldest goes first
    '{'{REQ_APPEND, 8'h07, 8'h09, 16'h1111}, 1'b1, '{1'b0, 16'h0000, 7'd4, STATUS_OK}},
    '{'{REQ_APPEND, 8'h07, 8'h09, 16'h2222}, 1'b1, '{1'b0, 16'h0000, 7'd5, STATUS_OK}},
    '{'{REQ_FIND,   8'h07, 8'h09, 16'h0000}, 1'b1, '{1'b1, 16'h1111, 7'd4, STATUS_OK}},
    '{'{REQ_FIND,   8'h07, 8'h09, 16'h0000}, 1'b1, '{1'b1, 16'h2222, 7'd3, STATUS_OK}},
    '{'{REQ_APPEND, 8'h00, 8'h00, 16'hbeef}, 1'b1, '{1'b0, 16'h0000, 7'd4, STATUS_OK}},
    '{'{REQ_FIND,   8'h00, 8'h00, 16'h0000}, 1'b1, '{1'b1, 16'h0000, 7'd3, STATUS_OK}},
    '{'{REQ_FIND,   8'h00, 8'h00, 16'h0000}, 1'b1, '{1'b1, 16'hbeef, 7'd2, STATUS_OK}},
    // value field of a find is ignored
    '{'{REQ_FIND,   8'haa, 8'h55, 16'hffff}, 1'b1, '{1'b1, 16'h5aa5, 7'd1, STATUS_OK}},
    '{'{REQ_APPEND, 8'h09, 8'h09, 16'h0001}, 1'b0, NO_RES},
    '{'{REQ_FIND,   8'h55, 8'haa, 16'h0000}, 1'b1, '{1'b1, 16'ha55a, 7'd1, STATUS_OK}},
    '{'{REQ_FIND,   8'h09, 8'h09, 16'h1234}, 1'b0, NO_RES},
    '{'{REQ_FIND,   8'h09, 8'h09, 16'h0000}, 1'b1, '{1'b0, 16'h0000, 7'd0, STATUS_OK}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = REQ_APPEND;
  logic [7:0]  coord_x = 8'h00;
  logic [7:0]  coord_y = 8'h00;
  logic [15:0] item_value = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        hit;
  logic [15:0] found_value;
  logic [6:0]  entry_count;
  logic        status;

  entry_t table_q[$];
  res_t   pending_results[$];
  res_t   oldest_result;
  int     errors = 0;
  int     total_sent = 0;
  int     sender_idle_pct = 13;
  int     recv_idle_pct = 64;
  int     hold_asked = 0;
  int     hold_seen = 0;
  int     hold_left = 0;
  int     cycle_count = 0;

  keyed_fifo_table_find_remove_top uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .item_value  (item_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .found_value (found_value),
    .entry_count (entry_count),
    .status      (status)
  );

  always #CLK_HALF clk = ~clk;

  // table behavior: applies one request to the shadow table, returns its result
  function automatic res_t predict_table_op(req_t r);
    res_t   res;
    entry_t e;
    int     where;
    res = '0;
    res.status = STATUS_OK;
    if (r.kind == REQ_APPEND) begin
      if (table_q.size() >= CAPACITY) begin
        res.status = STATUS_FULL;
      end else begin
        e.x = r.x;
        e.y = r.y;
        e.value = r.value;
        table_q.push_back(e);
      end
    end else begin
      where = -1;
      for (int i = 0; i < table_q.size(); i++) begin
        if (where < 0 && table_q[i].x == r.x && table_q[i].y == r.y) where = i;
      end
      if (where >= 0) begin
        res.hit = 1'b1;
        res.found_value = table_q[where].value;
        table_q.delete(where);
      end
    end
    res.entry_count = 7'(table_q.size());
    return res;
  endfunction

  // random request; finds mostly aim at a stored entry, coordinates often clustered
  function automatic req_t make_random_req(int mode);
    req_t r;
    int   pick;
    r.value = 16'($urandom);
    if ($urandom_range(1) == 1) begin
      r.x = 8'($urandom_range(3));
      r.y = 8'($urandom_range(3));
    end else begin
      r.x = 8'($urandom);
      r.y = 8'($urandom);
    end
    if (mode <= 3)
      r.kind = ($urandom_range(9) < 8) ? REQ_APPEND : REQ_FIND;
    else if (mode <= 7)
      r.kind = ($urandom_range(9) < 8) ? REQ_FIND : REQ_APPEND;
    else
      r.kind = 1'($urandom_range(1));
    if (r.kind == REQ_FIND && table_q.size() > 0 && $urandom_range(3) != 0) begin
      pick = $urandom_range(table_q.size() - 1);
      r.x = table_q[pick].x;
      r.y = table_q[pick].y;
    end
    return r;
  endfunction

  // one input transfer, with random gaps in front; records the expected result
  task automatic send_req(input req_t r, input logic known, input res_t typed_res);
    res_t predicted;
    if (total_sent == 150 || total_sent == PHASE_C_START + 20) hold_asked++;
    if (total_sent < PHASE_B_START) begin
      sender_idle_pct = 13;
      recv_idle_pct = 64;
    end else if (total_sent < PHASE_C_START) begin
      sender_idle_pct = 64;
      recv_idle_pct = 13;
    end else begin
      sender_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r.kind;
    coord_x <= r.x;
    coord_y <= r.y;
    item_value <= r.value;
    do @(posedge clk); while (in_stall);
    predicted = predict_table_op(r);
    pending_results.push_back(known ? typed_res : predicted);
    total_sent++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t result transfer with nothing expected: hit %0h value %0h count %0d status %0h",
                 $time, hit, found_value, entry_count, status);
        errors++;
      end else begin
        oldest_result = pending_results.pop_front();
        compare_field("hit", 16'(oldest_result.hit), 16'(hit));
        compare_field("found_value", oldest_result.found_value, found_value);
        compare_field("entry_count", 16'(oldest_result.entry_count), 16'(entry_count));
        compare_field("status", 16'(oldest_result.status), 16'(status));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout, %0d results still expected", $time, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    req_t fill_req;
    req_t rnd_req;
    res_t full_res;
    int   random_sent;
    int   mode;
    int   run_len;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (DIRECTED_ROWS[i])
      send_req(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].res);

    // fill to capacity, then one refused append and a find of the newest entry
    repeat (CAPACITY) begin
      fill_req.kind = REQ_APPEND;
      fill_req.x = 8'($urandom);
      fill_req.y = 8'($urandom);
      fill_req.value = 16'($urandom);
      send_req(fill_req, 1'b0, NO_RES);
    end
    full_res = '0;
    full_res.entry_count = 7'(CAPACITY);
    full_res.status = STATUS_FULL;
    fill_req.value = 16'h0f0f;
    send_req(fill_req, 1'b1, full_res);
    fill_req.kind = REQ_FIND;
    fill_req.x = table_q[$].x;
    fill_req.y = table_q[$].y;
    send_req(fill_req, 1'b0, NO_RES);

    // random runs: append-heavy, find-heavy and mixed
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      mode = $urandom_range(9);
      run_len = $urandom_range(100, 5);
      while (run_len > 0 && random_sent < RANDOM_ITEMS) begin
        rnd_req = make_random_req(mode);
        send_req(rnd_req, 1'b0, NO_RES);
        random_sent++;
        run_len--;
      end
    end

    // wait out the remaining results
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
